// ===== rtl/core/rv32i_instruction_encoder_macros.svh =====
`ifndef RV32I_INSTRUCTION_ENCODER_MACROS_SVH
`define RV32I_INSTRUCTION_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rie_pkg.sv =====
`default_nettype none

package rie_pkg;

  // base opcodes
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [6:0]  F7_ALT      = 7'h20;
  localparam logic [6:0]  F7_BASE     = 7'h00;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_IMM     = 3'd2;
  localparam logic [2:0] ST_ALIGN   = 3'd3;
  localparam logic [2:0] ST_OFFSET  = 3'd4;
  localparam logic [2:0] ST_SHIFT   = 3'd5;

  // mnemonic codes
  localparam logic [5:0] MN_NOP    = 6'd0;
  localparam logic [5:0] MN_ADD    = 6'd1;
  localparam logic [5:0] MN_SUB    = 6'd2;
  localparam logic [5:0] MN_SLL    = 6'd3;
  localparam logic [5:0] MN_SLT    = 6'd4;
  localparam logic [5:0] MN_SLTU   = 6'd5;
  localparam logic [5:0] MN_XOR    = 6'd6;
  localparam logic [5:0] MN_SRL    = 6'd7;
  localparam logic [5:0] MN_SRA    = 6'd8;
  localparam logic [5:0] MN_OR     = 6'd9;
  localparam logic [5:0] MN_AND    = 6'd10;
  localparam logic [5:0] MN_ADDI   = 6'd11;
  localparam logic [5:0] MN_SLTI   = 6'd12;
  localparam logic [5:0] MN_SLTIU  = 6'd13;
  localparam logic [5:0] MN_XORI   = 6'd14;
  localparam logic [5:0] MN_ORI    = 6'd15;
  localparam logic [5:0] MN_ANDI   = 6'd16;
  localparam logic [5:0] MN_SLLI   = 6'd17;
  localparam logic [5:0] MN_SRLI   = 6'd18;
  localparam logic [5:0] MN_SRAI   = 6'd19;
  localparam logic [5:0] MN_LUI    = 6'd20;
  localparam logic [5:0] MN_JAL    = 6'd21;
  localparam logic [5:0] MN_JALR   = 6'd22;
  localparam logic [5:0] MN_LB     = 6'd23;
  localparam logic [5:0] MN_LH     = 6'd24;
  localparam logic [5:0] MN_LW     = 6'd25;
  localparam logic [5:0] MN_LBU    = 6'd26;
  localparam logic [5:0] MN_LHU    = 6'd27;
  localparam logic [5:0] MN_SB     = 6'd28;
  localparam logic [5:0] MN_SH     = 6'd29;
  localparam logic [5:0] MN_SW     = 6'd30;
  localparam logic [5:0] MN_BEQ    = 6'd31;
  localparam logic [5:0] MN_BNE    = 6'd32;
  localparam logic [5:0] MN_BLT    = 6'd33;
  localparam logic [5:0] MN_BGE    = 6'd34;
  localparam logic [5:0] MN_BLTU   = 6'd35;
  localparam logic [5:0] MN_BGEU   = 6'd36;
  localparam logic [5:0] MN_AUIPC  = 6'd37;
  localparam logic [5:0] MN_ECALL  = 6'd38;
  localparam logic [5:0] MN_EBREAK = 6'd39;

  typedef enum logic [3:0] {
    FMT_NOP,
    FMT_R,
    FMT_I,
    FMT_SHIFT,
    FMT_U,
    FMT_J,
    FMT_S,
    FMT_B,
    FMT_ECALL,
    FMT_EBREAK,
    FMT_BAD
  } fmt_t;

  typedef struct packed {
    fmt_t       fmt;
    logic [2:0] funct3;
    logic [6:0] funct7;
    logic [6:0] opcode;
  } ctrl_t;

  typedef struct packed {
    logic [5:0]        req_type;
    logic [4:0]        dest_reg;
    logic [4:0]        src_reg1;
    logic [4:0]        src_reg2;
    logic signed [31:0] immediate;
    logic [31:0]       current_address;
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/core/rie_if.sv =====
`default_nettype none

interface rie_req_if;
  logic               valid;
  logic               ready;
  logic [5:0]         req_type;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg1;
  logic [4:0]         src_reg2;
  logic signed [31:0] immediate;
  logic [31:0]        current_address;

  modport source (
    output valid, req_type, dest_reg, src_reg1, src_reg2, immediate, current_address,
    input  ready
  );
  modport sink (
    input  valid, req_type, dest_reg, src_reg1, src_reg2, immediate, current_address,
    output ready
  );
endinterface

interface rie_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] encoded_word;
  logic [2:0]  status;

  modport source (
    output valid, encoded_word, status,
    input  ready
  );
  modport sink (
    input  valid, encoded_word, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/rie_decode.sv =====
`default_nettype none

module rie_decode (
  input  logic [5:0]     code,
  output rie_pkg::ctrl_t ctrl
);
  import rie_pkg::*;

  always_comb begin
    ctrl.fmt    = FMT_BAD;
    ctrl.funct3 = 3'd0;
    ctrl.funct7 = F7_BASE;
    ctrl.opcode = OP_IMM;
    unique case (code)
      MN_NOP:    ctrl.fmt = FMT_NOP;
      MN_ADD:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; end
      MN_SUB:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct7 = F7_ALT; end
      MN_SLL:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd1; end
      MN_SLT:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd2; end
      MN_SLTU:   begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd3; end
      MN_XOR:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd4; end
      MN_SRL:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd5; end
      MN_SRA:    begin
        ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd5; ctrl.funct7 = F7_ALT;
      end
      MN_OR:     begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd6; end
      MN_AND:    begin ctrl.fmt = FMT_R; ctrl.opcode = OP_REG; ctrl.funct3 = 3'd7; end
      MN_ADDI:   ctrl.fmt = FMT_I;
      MN_SLTI:   begin ctrl.fmt = FMT_I; ctrl.funct3 = 3'd2; end
      MN_SLTIU:  begin ctrl.fmt = FMT_I; ctrl.funct3 = 3'd3; end
      MN_XORI:   begin ctrl.fmt = FMT_I; ctrl.funct3 = 3'd4; end
      MN_ORI:    begin ctrl.fmt = FMT_I; ctrl.funct3 = 3'd6; end
      MN_ANDI:   begin ctrl.fmt = FMT_I; ctrl.funct3 = 3'd7; end
      MN_SLLI:   begin ctrl.fmt = FMT_SHIFT; ctrl.funct3 = 3'd1; end
      MN_SRLI:   begin ctrl.fmt = FMT_SHIFT; ctrl.funct3 = 3'd5; end
      MN_SRAI:   begin ctrl.fmt = FMT_SHIFT; ctrl.funct3 = 3'd5; ctrl.funct7 = F7_ALT; end
      MN_LUI:    begin ctrl.fmt = FMT_U; ctrl.opcode = OP_LUI; end
      MN_AUIPC:  begin ctrl.fmt = FMT_U; ctrl.opcode = OP_AUIPC; end
      MN_JAL:    begin ctrl.fmt = FMT_J; ctrl.opcode = OP_JAL; end
      MN_JALR:   begin ctrl.fmt = FMT_I; ctrl.opcode = OP_JALR; end
      MN_LB:     begin ctrl.fmt = FMT_I; ctrl.opcode = OP_LOAD; end
      MN_LH:     begin ctrl.fmt = FMT_I; ctrl.opcode = OP_LOAD; ctrl.funct3 = 3'd1; end
      MN_LW:     begin ctrl.fmt = FMT_I; ctrl.opcode = OP_LOAD; ctrl.funct3 = 3'd2; end
      MN_LBU:    begin ctrl.fmt = FMT_I; ctrl.opcode = OP_LOAD; ctrl.funct3 = 3'd4; end
      MN_LHU:    begin ctrl.fmt = FMT_I; ctrl.opcode = OP_LOAD; ctrl.funct3 = 3'd5; end
      MN_SB:     begin ctrl.fmt = FMT_S; ctrl.opcode = OP_STORE; end
      MN_SH:     begin ctrl.fmt = FMT_S; ctrl.opcode = OP_STORE; ctrl.funct3 = 3'd1; end
      MN_SW:     begin ctrl.fmt = FMT_S; ctrl.opcode = OP_STORE; ctrl.funct3 = 3'd2; end
      MN_BEQ:    begin ctrl.fmt = FMT_B; ctrl.opcode = OP_BRANCH; end
      MN_BNE:    begin ctrl.fmt = FMT_B; ctrl.opcode = OP_BRANCH; ctrl.funct3 = 3'd1; end
      MN_BLT:    begin ctrl.fmt = FMT_B; ctrl.opcode = OP_BRANCH; ctrl.funct3 = 3'd4; end
      MN_BGE:    begin ctrl.fmt = FMT_B; ctrl.opcode = OP_BRANCH; ctrl.funct3 = 3'd5; end
      MN_BLTU:   begin ctrl.fmt = FMT_B; ctrl.opcode = OP_BRANCH; ctrl.funct3 = 3'd6; end
      MN_BGEU:   begin ctrl.fmt = FMT_B; ctrl.opcode = OP_BRANCH; ctrl.funct3 = 3'd7; end
      MN_ECALL:  ctrl.fmt = FMT_ECALL;
      MN_EBREAK: ctrl.fmt = FMT_EBREAK;
      default:   ctrl.fmt = FMT_BAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rie_encode.sv =====
`default_nettype none

module rie_encode (
  input  rie_pkg::ctrl_t ctrl,
  input  rie_pkg::req_t  item,
  output logic [31:0]    encoded_word,
  output logic [2:0]     status
);
  import rie_pkg::*;

  logic [31:0] imm;
  logic [31:0] off;
  logic        imm_ok;
  logic        shamt_ok;
  logic        b_ok;
  logic        j_ok;
  logic [31:0] word;

  assign imm = item.immediate;
  // pc-relative offset, wraps mod 2^32
  assign off = imm - item.current_address;

  assign imm_ok   = (imm[31:11] == {21{imm[11]}});
  assign shamt_ok = (imm[31:5] == 27'd0);
  assign b_ok     = (off[31:12] == {20{off[12]}});
  assign j_ok     = (off[31:20] == {12{off[20]}});

  always_comb begin
    word   = 32'd0;
    status = ST_OK;
    unique case (ctrl.fmt)
      FMT_NOP: word = {25'd0, OP_IMM};
      FMT_R: word = {ctrl.funct7, item.src_reg2, item.src_reg1, ctrl.funct3,
                     item.dest_reg, ctrl.opcode};
      FMT_I: begin
        if (!imm_ok) status = ST_IMM;
        else word = {imm[11:0], item.src_reg1, ctrl.funct3, item.dest_reg, ctrl.opcode};
      end
      FMT_SHIFT: begin
        if (!shamt_ok) status = ST_SHIFT;
        else word = {ctrl.funct7, imm[4:0], item.src_reg1, ctrl.funct3,
                     item.dest_reg, ctrl.opcode};
      end
      FMT_U: word = {imm[31:12], item.dest_reg, ctrl.opcode};
      FMT_J: begin
        // alignment wins over range
        if (off[0]) status = ST_ALIGN;
        else if (!j_ok) status = ST_OFFSET;
        else word = {off[20], off[10:1], off[11], off[19:12], item.dest_reg, ctrl.opcode};
      end
      FMT_S: begin
        if (!imm_ok) status = ST_IMM;
        else word = {imm[11:5], item.src_reg2, item.src_reg1, ctrl.funct3, imm[4:0],
                     ctrl.opcode};
      end
      FMT_B: begin
        if (off[0]) status = ST_ALIGN;
        else if (!b_ok) status = ST_OFFSET;
        else word = {off[12], off[10:5], item.src_reg2, item.src_reg1, ctrl.funct3,
                     off[4:1], off[11], ctrl.opcode};
      end
      FMT_ECALL:  word = WORD_ECALL;
      FMT_EBREAK: word = WORD_EBREAK;
      default:    status = ST_UNKNOWN;
    endcase
  end

  assign encoded_word = (status == ST_OK) ? word : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/core/rv32i_instruction_encoder.sv =====
// an accepted input beat passes the input register, then the result register, to reach rsp
// throughput: one instruction per cycle while rsp is ready, set by the input and result registers
// while a finished word waits on rsp, the input register can still take a beat if it is empty
// reset: synchronous, active high; clears both valid flags, payload is not reset
`default_nettype none
`include "rv32i_instruction_encoder_macros.svh"

module rv32i_instruction_encoder (
  input  logic      clk,
  input  logic      rst,
  rie_req_if.sink   req,
  rie_rsp_if.source rsp
);
  import rie_pkg::*;

  logic        in_valid;
  req_t        in_item;
  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_status;

  logic        out_adv;
  logic        in_adv;
  ctrl_t       ctrl;
  logic [31:0] word_next;
  logic [2:0]  status_next;

  assign out_adv   = !out_valid || rsp.ready;
  assign in_adv    = !in_valid || out_adv;
  assign req.ready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && req.valid) begin
      in_item.req_type        <= req.req_type;
      in_item.dest_reg        <= req.dest_reg;
      in_item.src_reg1        <= req.src_reg1;
      in_item.src_reg2        <= req.src_reg2;
      in_item.immediate       <= req.immediate;
      in_item.current_address <= req.current_address;
    end
  end

  rie_decode u_decode (
    .code (in_item.req_type),
    .ctrl (ctrl)
  );

  rie_encode u_encode (
    .ctrl         (ctrl),
    .item         (in_item),
    .encoded_word (word_next),
    .status       (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      out_word   <= word_next;
      out_status <= status_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.encoded_word = out_word;
  assign rsp.status       = out_status;

  `RIE_ASSERT_NOW(a_err_word_zero, out_valid && out_status != ST_OK, out_word == 32'd0,
                  "word not zero on error status")
  `RIE_ASSERT_NOW(a_status_range, out_valid, out_status <= ST_SHIFT, "status code out of range")
  `RIE_ASSERT_NEXT(a_in_capture, req.valid && req.ready, in_valid, "beat lost at input register")
  `RIE_ASSERT_NEXT(a_out_capture, in_valid && out_adv, out_valid, "beat lost at result register")

endmodule

`default_nettype wire

// ===== bench/rv32i_instruction_encoder_tb.sv =====
`timescale 1ns / 1ps

import rie_pkg::*;

typedef struct packed {
  logic [31:0] word;
  logic [2:0]  status;
} enc_result_t;

class encoding_scoreboard;
  enc_result_t expected_words[$];
  int          mismatch_count;

  function new();
    mismatch_count = 0;
  endfunction

  static function enc_result_t encode_instr(req_t r);
    fmt_t               fm;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic [6:0]         opc;
    logic signed [31:0] imm;
    logic [31:0]        off;
    logic signed [31:0] soff;
    enc_result_t        res;
    fm = FMT_BAD;
    f3 = 3'd0;
    f7 = F7_BASE;
    opc = OP_IMM;
    imm = r.immediate;
    off = r.immediate - r.current_address;
    soff = off;
    res.word = '0;
    res.status = ST_OK;
    case (r.req_type)
      MN_NOP:    fm = FMT_NOP;
      MN_ADD:    begin fm = FMT_R; f3 = 3'd0; end
      MN_SUB:    begin fm = FMT_R; f3 = 3'd0; f7 = F7_ALT; end
      MN_SLL:    begin fm = FMT_R; f3 = 3'd1; end
      MN_SLT:    begin fm = FMT_R; f3 = 3'd2; end
      MN_SLTU:   begin fm = FMT_R; f3 = 3'd3; end
      MN_XOR:    begin fm = FMT_R; f3 = 3'd4; end
      MN_SRL:    begin fm = FMT_R; f3 = 3'd5; end
      MN_SRA:    begin fm = FMT_R; f3 = 3'd5; f7 = F7_ALT; end
      MN_OR:     begin fm = FMT_R; f3 = 3'd6; end
      MN_AND:    begin fm = FMT_R; f3 = 3'd7; end
      MN_ADDI:   begin fm = FMT_I; f3 = 3'd0; end
      MN_SLTI:   begin fm = FMT_I; f3 = 3'd2; end
      MN_SLTIU:  begin fm = FMT_I; f3 = 3'd3; end
      MN_XORI:   begin fm = FMT_I; f3 = 3'd4; end
      MN_ORI:    begin fm = FMT_I; f3 = 3'd6; end
      MN_ANDI:   begin fm = FMT_I; f3 = 3'd7; end
      MN_SLLI:   begin fm = FMT_SHIFT; f3 = 3'd1; end
      MN_SRLI:   begin fm = FMT_SHIFT; f3 = 3'd5; end
      MN_SRAI:   begin fm = FMT_SHIFT; f3 = 3'd5; f7 = F7_ALT; end
      MN_LUI:    begin fm = FMT_U; opc = OP_LUI; end
      MN_AUIPC:  begin fm = FMT_U; opc = OP_AUIPC; end
      MN_JAL:    fm = FMT_J;
      MN_JALR:   begin fm = FMT_I; f3 = 3'd0; opc = OP_JALR; end
      MN_LB:     begin fm = FMT_I; f3 = 3'd0; opc = OP_LOAD; end
      MN_LH:     begin fm = FMT_I; f3 = 3'd1; opc = OP_LOAD; end
      MN_LW:     begin fm = FMT_I; f3 = 3'd2; opc = OP_LOAD; end
      MN_LBU:    begin fm = FMT_I; f3 = 3'd4; opc = OP_LOAD; end
      MN_LHU:    begin fm = FMT_I; f3 = 3'd5; opc = OP_LOAD; end
      MN_SB:     begin fm = FMT_S; f3 = 3'd0; end
      MN_SH:     begin fm = FMT_S; f3 = 3'd1; end
      MN_SW:     begin fm = FMT_S; f3 = 3'd2; end
      MN_BEQ:    begin fm = FMT_B; f3 = 3'd0; end
      MN_BNE:    begin fm = FMT_B; f3 = 3'd1; end
      MN_BLT:    begin fm = FMT_B; f3 = 3'd4; end
      MN_BGE:    begin fm = FMT_B; f3 = 3'd5; end
      MN_BLTU:   begin fm = FMT_B; f3 = 3'd6; end
      MN_BGEU:   begin fm = FMT_B; f3 = 3'd7; end
      MN_ECALL:  fm = FMT_ECALL;
      MN_EBREAK: fm = FMT_EBREAK;
      default:   fm = FMT_BAD;
    endcase
    case (fm)
      FMT_NOP: res.word = {25'd0, OP_IMM};
      FMT_R: res.word = {f7, r.src_reg2, r.src_reg1, f3, r.dest_reg, OP_REG};
      FMT_I: begin
        if (imm < -2048 || imm > 2047) res.status = ST_IMM;
        else res.word = {imm[11:0], r.src_reg1, f3, r.dest_reg, opc};
      end
      FMT_SHIFT: begin
        if (imm < 0 || imm > 31) res.status = ST_SHIFT;
        else res.word = {f7, imm[4:0], r.src_reg1, f3, r.dest_reg, OP_IMM};
      end
      // low 12 bits of the upper immediate are simply dropped
      FMT_U: res.word = {imm[31:12], r.dest_reg, opc};
      FMT_J: begin
        if (off[0]) res.status = ST_ALIGN;
        else if (soff < -1048576 || soff > 1048575) res.status = ST_OFFSET;
        else res.word = {off[20], off[10:1], off[11], off[19:12], r.dest_reg, OP_JAL};
      end
      FMT_S: begin
        if (imm < -2048 || imm > 2047) res.status = ST_IMM;
        else res.word = {imm[11:5], r.src_reg2, r.src_reg1, f3, imm[4:0], OP_STORE};
      end
      FMT_B: begin
        if (off[0]) res.status = ST_ALIGN;
        else if (soff < -4096 || soff > 4095) res.status = ST_OFFSET;
        else res.word = {off[12], off[10:5], r.src_reg2, r.src_reg1, f3, off[4:1], off[11],
                         OP_BRANCH};
      end
      FMT_ECALL:  res.word = WORD_ECALL;
      FMT_EBREAK: res.word = WORD_EBREAK;
      default:    res.status = ST_UNKNOWN;
    endcase
    if (res.status != ST_OK) res.word = '0;
    return res;
  endfunction

  function void note_instr(req_t r);
    expected_words.push_back(encode_instr(r));
  endfunction

  function void check_word(logic [31:0] word, logic [2:0] status);
    enc_result_t want;
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result beat: word %h status %0d", word, status);
    end else begin
      want = expected_words.pop_front();
      if (word !== want.word || status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected word %h status %0d, got word %h status %0d",
                   want.word, want.status, word, status);
      end
    end
  endfunction
endclass

module rv32i_instruction_encoder_tb;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 10;
  localparam int PHASE_ITEMS    = 320;
  localparam int EDGE_VALS [18] = '{-1048577, -1048576, 1048574, 1048575, 1048576,
                                    -4097, -4096, 4094, 4095, 4096,
                                    -2049, -2048, 2047, 2048, -1, 0, 31, 32};

  logic clk;
  logic rst;
  int   req_idle_pct;
  int   rsp_stall_pct;
  int   stall_cycles;

  encoding_scoreboard sb;

  rie_req_if req_ch();
  rie_rsp_if rsp_ch();

  rv32i_instruction_encoder DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    req_t seen;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.req_type = req_ch.req_type;
        seen.dest_reg = req_ch.dest_reg;
        seen.src_reg1 = req_ch.src_reg1;
        seen.src_reg2 = req_ch.src_reg2;
        seen.immediate = req_ch.immediate;
        seen.current_address = req_ch.current_address;
        sb.note_instr(seen);
      end
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_word(rsp_ch.encoded_word, rsp_ch.status);
    end
  end

  // counts cycles without any beat on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("rv32i_instruction_encoder test failed");
      $finish;
    end
  end

  task automatic send_instr(input logic [5:0] code, input logic [4:0] rd, input logic [4:0] rs1,
                            input logic [4:0] rs2, input logic [31:0] imm,
                            input logic [31:0] addr);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= code;
    req_ch.dest_reg <= rd;
    req_ch.src_reg1 <= rs1;
    req_ch.src_reg2 <= rs2;
    req_ch.immediate <= imm;
    req_ch.current_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_instr();
    logic [5:0]  code;
    logic [31:0] addr;
    logic [31:0] imm;
    int          off;
    int          pick;
    bit          relative;
    code = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
    addr = $urandom();
    relative = (code == MN_JAL) || (code >= MN_BEQ && code <= MN_BGEU);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      imm = $urandom();
    end else if (pick == 1) begin
      off = EDGE_VALS[$urandom_range(0, 17)];
      imm = relative ? addr + off : off;
    end else if (code == MN_JAL) begin
      off = int'($urandom_range(0, 2200000)) - 1100000;
      if ($urandom_range(0, 6) != 0) off = off & ~1;
      imm = addr + off;
    end else if (relative) begin
      off = int'($urandom_range(0, 8600)) - 4300;
      if ($urandom_range(0, 6) != 0) off = off & ~1;
      imm = addr + off;
    end else if (code >= MN_SLLI && code <= MN_SRAI) begin
      imm = $urandom_range(0, 31);
    end else begin
      imm = int'($urandom_range(0, 4095)) - 2048;
    end
    send_instr(code, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
               5'($urandom_range(0, 31)), imm, addr);
  endtask

  // hold the sender off until every outstanding word has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    // let the monitor note the last accepted beat first
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    req_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_instr();
    wait_drained();
  endtask

  initial begin
    sb = new();
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= '0;
    req_ch.dest_reg <= '0;
    req_ch.src_reg1 <= '0;
    req_ch.src_reg2 <= '0;
    req_ch.immediate <= '0;
    req_ch.current_address <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fields a mnemonic does not use must not leak into the word
    send_instr(MN_NOP, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(MN_ADD, 5'd31, 5'd0, 5'd31, 32'h1234_5678, 32'h0);
    send_instr(MN_SRA, 5'd0, 5'd31, 5'd0, 32'h0, 32'h0);
    send_instr(MN_ADDI, 5'd1, 5'd2, 5'd0, 2047, 32'h0);
    send_instr(MN_ANDI, 5'd31, 5'd31, 5'd0, -2048, 32'h0);
    send_instr(MN_SLTI, 5'd1, 5'd2, 5'd0, 2048, 32'h0);
    send_instr(MN_SLTIU, 5'd1, 5'd2, 5'd0, -2049, 32'h0);
    send_instr(MN_SLLI, 5'd3, 5'd4, 5'd0, 31, 32'h0);
    send_instr(MN_SRAI, 5'd31, 5'd31, 5'd0, 31, 32'h0);
    send_instr(MN_SRLI, 5'd3, 5'd4, 5'd0, 32, 32'h0);
    send_instr(MN_SLLI, 5'd3, 5'd4, 5'd0, -1, 32'h0);
    send_instr(MN_LUI, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'h0);
    send_instr(MN_AUIPC, 5'd5, 5'd0, 5'd0, 32'h8000_0FFF, 32'h0);
    send_instr(MN_JAL, 5'd1, 5'd0, 5'd0, 32'h0000_1000 + 1048574, 32'h0000_1000);
    send_instr(MN_JAL, 5'd1, 5'd0, 5'd0, 32'h0020_0000 - 1048576, 32'h0020_0000);
    send_instr(MN_JAL, 5'd1, 5'd0, 5'd0, 32'h0000_1000 + 1048576, 32'h0000_1000);
    send_instr(MN_JAL, 5'd1, 5'd0, 5'd0, 32'h0000_1001, 32'h0000_1000);
    send_instr(MN_JALR, 5'd1, 5'd31, 5'd0, -2048, 32'h0);
    send_instr(MN_LW, 5'd7, 5'd8, 5'd0, 2047, 32'h0);
    send_instr(MN_SW, 5'd0, 5'd31, 5'd31, -2048, 32'h0);
    send_instr(MN_SB, 5'd0, 5'd1, 5'd2, 2048, 32'h0);
    // branch across the top of the address space
    send_instr(MN_BEQ, 5'd0, 5'd1, 5'd2, 32'h0000_0FEE, 32'hFFFF_FFF0);
    send_instr(MN_BGEU, 5'd0, 5'd31, 5'd31, 32'h0000_0000, 32'h0000_1000);
    send_instr(MN_BNE, 5'd0, 5'd1, 5'd2, 32'h0000_2000, 32'h0000_1000);
    // odd and far: alignment wins over range
    send_instr(MN_BLT, 5'd0, 5'd1, 5'd2, 32'h8000_0001, 32'h0000_1000);
    send_instr(MN_ECALL, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'h0);
    send_instr(MN_EBREAK, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'h0);
    send_instr(6'd40, 5'd1, 5'd1, 5'd1, 32'h0, 32'h0);
    send_instr(6'd63, 5'd1, 5'd1, 5'd1, 32'h0, 32'h0);
    wait_drained();

    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(35, 35);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_words.size() == 0) begin
      $display("rv32i_instruction_encoder test passed");
    end else begin
      $display("rv32i_instruction_encoder test failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rie_pkg.sv
rtl/core/rie_if.sv
rtl/core/rie_decode.sv
rtl/core/rie_encode.sv
rtl/core/rv32i_instruction_encoder.sv
bench/rv32i_instruction_encoder_tb.sv
